// ----- hw/rtl/pcps_pkg.sv -----
// Shared types, constants and the word address helper for the planar cursor pixel store.
`default_nettype none

package pcps_pkg;

    // Store geometry: 32 words, each holding 8 byte lanes.
    // Lane {plane, pair}: pair 0 is opacity, pair 1 is colour.
    localparam int unsigned LANE_W     = 8;
    localparam int unsigned NUM_PLANES = 4;
    localparam int unsigned NUM_LANES  = 2 * NUM_PLANES;
    localparam int unsigned WORD_W     = LANE_W * NUM_LANES;
    localparam int unsigned WORD_DEPTH = 32;
    localparam int unsigned ADDR_W     = $clog2(WORD_DEPTH);
    localparam int unsigned LANE_SEL_W = $clog2(NUM_LANES);
    localparam int unsigned BIT_SEL_W  = $clog2(LANE_W);

    // Item kinds
    localparam logic [2:0] K_READ_PIXEL   = 3'd0;
    localparam logic [2:0] K_WRITE_COLOR  = 3'd1;
    localparam logic [2:0] K_WRITE_OPAC   = 3'd2;
    localparam logic [2:0] K_LOAD_RAW     = 3'd3;
    localparam logic [2:0] K_READ_RAW     = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] px;
        logic [4:0] py;
        logic [3:0] nibble;
        logic [7:0] byte_index;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pixel_color;
        logic [3:0] pixel_opacity;
        logic       is_clear;
        logic [7:0] raw_out;
        logic       in_bounds;
    } t_out_item;

    // Result of the modify step: write-back request plus the result item
    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wr_data;
        t_out_item         result;
    } t_rmw;

    // Word address of an item: raw kinds use the byte index, pixel kinds the
    // row and the column half (columns 0-7 live in the odd byte of a pair).
    function automatic logic [ADDR_W-1:0] word_addr(input t_in_item item);
        logic [ADDR_W-1:0] addr;
        case (item.kind)
            K_LOAD_RAW, K_READ_RAW: addr = {item.byte_index[5:2], item.byte_index[0]};
            default:                addr = {item.py[3:0], ~item.px[3]};
        endcase
        return addr;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcps_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module pcps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pcps_rmw.sv -----
// Modify step: extracts pixel or raw data from a store word and builds its write-back.
`default_nettype none

module pcps_rmw (
    input  wire pcps_pkg::t_in_item            i_item,
    input  wire logic [pcps_pkg::WORD_W-1:0]   i_rd_data,
    output pcps_pkg::t_rmw                     o_rmw
);
    import pcps_pkg::*;

    logic [LANE_W-1:0]     lanes     [NUM_LANES];
    logic [LANE_W-1:0]     new_lanes [NUM_LANES];
    logic [BIT_SEL_W-1:0]  bit_sel;
    logic [LANE_SEL_W-1:0] raw_lane;
    logic                  in_b;
    logic [3:0]            color;
    logic [3:0]            opac;

    assign in_b     = ~i_item.px[4] & ~i_item.py[4];
    assign bit_sel  = ~i_item.px[2:0];
    assign raw_lane = {i_item.byte_index[7:6], i_item.byte_index[1]};

    // Split the word into byte lanes and gather one bit per plane
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            lanes[l] = i_rd_data[l*LANE_W +: LANE_W];
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            color[p] = lanes[2*p+1][bit_sel];
            opac[p]  = lanes[2*p][bit_sel];
        end
    end

    // Decode the kind: result fields, lane updates and write enable
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            new_lanes[l] = lanes[l];
        end
        o_rmw.wr_en  = 1'b0;
        o_rmw.result = '0;
        case (i_item.kind)
            K_READ_PIXEL: begin
                o_rmw.result.in_bounds     = in_b;
                o_rmw.result.pixel_color   = in_b ? color : 4'd0;
                o_rmw.result.pixel_opacity = in_b ? opac : 4'd0;
                o_rmw.result.is_clear      = ~in_b | (opac == 4'd0);
            end
            K_WRITE_COLOR: begin
                o_rmw.result.in_bounds = in_b;
                o_rmw.wr_en            = in_b;
                for (int p = 0; p < NUM_PLANES; p++) begin
                    new_lanes[2*p+1][bit_sel] = i_item.nibble[p];
                end
            end
            K_WRITE_OPAC: begin
                o_rmw.result.in_bounds = in_b;
                o_rmw.wr_en            = in_b;
                for (int p = 0; p < NUM_PLANES; p++) begin
                    new_lanes[2*p][bit_sel] = i_item.nibble[p];
                end
            end
            K_LOAD_RAW: begin
                o_rmw.wr_en         = 1'b1;
                new_lanes[raw_lane] = i_item.byte_value;
            end
            K_READ_RAW: begin
                o_rmw.result.raw_out = lanes[raw_lane];
            end
            default: begin
                o_rmw.wr_en = 1'b0;
            end
        endcase
        for (int l = 0; l < NUM_LANES; l++) begin
            o_rmw.wr_data[l*LANE_W +: LANE_W] = new_lanes[l];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/planar_cursor_pixel_store_core.sv -----
// Top level of the planar cursor pixel store: sequencer, store RAM and result register.
//
// Usage:
//   Input channel (i_valid / o_ready / i_item) carries one command transaction:
//   read pixel, write colour, write opacity, load raw byte or read raw byte.
//   Output channel (o_valid / i_ready / o_item) returns exactly one result
//   transaction per command, in order.
//   The accept cycle reads one 64-bit store word (all four planes of one
//   byte pair); the access state then modifies and writes it back and loads
//   the result register. A new command is accepted only once the single
//   read-modify-write pass through the store RAM has finished.
//   The result register lets the next command be accepted while a result
//   waits; if the receiver still stalls when the next result is ready, the
//   sequencer holds in its access state and o_ready stays low.
//   Reset clears the sequencer and the output valid flag only; the store has
//   no defined contents and must be loaded before pixels are read.
`default_nettype none

module planar_cursor_pixel_store_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire pcps_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output pcps_pkg::t_out_item      o_item
);
    import pcps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_ACCESS = 2'b10
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [ADDR_W-1:0] r_addr;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out;
    logic [WORD_W-1:0] rd_data;
    t_rmw              rmw;
    logic              in_accept;
    logic              finish;
    logic              ram_wr_en;

    assign o_ready   = (r_state == S_IDLE);
    assign in_accept = i_valid & o_ready;
    assign finish    = (r_state == S_ACCESS) & (~r_out_valid | i_ready);
    assign ram_wr_en = finish & rmw.wr_en;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    // Store: 32 words x 8 lanes
    pcps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (rmw.wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (word_addr(i_item)),
        .o_rd_data (rd_data)
    );

    // Modify step on the word read back
    pcps_rmw u_rmw (
        .i_item    (r_item),
        .i_rd_data (rd_data),
        .o_rmw     (rmw)
    );

    // Sequencer and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                if (finish) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Captured command and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_item;
            r_addr <= word_addr(i_item);
        end
        if (finish) begin
            r_out <= rmw.result;
        end
    end

`ifndef NO_ASSERTIONS
    // Store is written only on the way out of the access state
    a_wr_only_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |=> (r_state == S_IDLE))
        else $error("store written outside access state");

    // An accepted transaction is worked on in the next cycle
    a_accept_to_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_ACCESS))
        else $error("accepted transaction did not enter access state");

    // Finishing an access always presents a result
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_valid)
        else $error("finished access produced no result");

    // No write-back while idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_wr_en)
        else $error("store write while idle");
`endif

endmodule

`default_nettype wire
